@@ rtl/core/tsq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and codes for the two-stack queue: operation modes, result
// status codes and the controller state type.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MOVE,
        S_POP_RD,
        S_POP_WAIT
    } t_state;

endpackage

@@ rtl/core/two_stack_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_queue
// First-in first-out queue built from an input stack and an output stack,
// each held in a single-port synchronous memory.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item. An enqueue writes its
// result to the output register and makes the input side ready again in the
// same cycle. A dequeue that finds the output stack non-empty first reads the
// output-stack memory, whose read is registered, and then writes the result.
// A dequeue that finds the output stack empty first moves all input-stack
// entries across, one entry per cycle through the read port of the
// input-stack memory, and then reads the output stack in the same way. Each
// entry crosses only once. One item is worked on at a time, and a new item
// is taken as soon as the previous one has its result in the output
// register, even while that result still waits to be taken; a result that
// waits holds the next item back before it can finish. No clearing pass is
// needed after reset.
module two_stack_queue
    import tsq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input items.
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,   // [31:0] value_in
    input  logic [0:0]        i_s_axis_tuser,   // [0] mode
    // Result items.
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,   // [31:0] value_out
    output logic [STAT_W-1:0] o_m_axis_tuser    // [1:0] status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_in_mem  [DEPTH];
    logic [DATA_W-1:0] r_out_mem [DEPTH];
    logic [DATA_W-1:0] r_in_rdata;
    logic [DATA_W-1:0] r_out_rdata;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_in_cnt, n_in_cnt;
    logic [CW-1:0]     r_out_cnt, n_out_cnt;
    logic              r_mv_pend, n_mv_pend;
    logic              r_mode;
    logic [DATA_W-1:0] r_value;
    logic              r_o_valid, n_o_valid;
    logic [DATA_W-1:0] r_o_data, n_o_data;
    logic [STAT_W-1:0] r_o_status, n_o_status;

    logic              in_we, in_re, out_we, out_re;
    logic [AW-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
    logic [CW-1:0]     in_cnt_m1, out_cnt_m1;
    logic              accept, out_free, in_full;

    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_o_valid || i_m_axis_tready;
    assign in_full    = (r_in_cnt == CW'(DEPTH));
    assign in_cnt_m1  = r_in_cnt - CW'(1);
    assign out_cnt_m1 = r_out_cnt - CW'(1);

    assign in_waddr  = r_in_cnt[AW-1:0];
    assign in_raddr  = in_cnt_m1[AW-1:0];
    assign out_waddr = r_out_cnt[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_in_cnt   = r_in_cnt;
        n_out_cnt  = r_out_cnt;
        n_mv_pend  = r_mv_pend;
        n_o_valid  = r_o_valid && !i_m_axis_tready;
        n_o_data   = r_o_data;
        n_o_status = r_o_status;
        in_we      = 1'b0;
        in_re      = 1'b0;
        out_we     = 1'b0;
        out_re     = 1'b0;
        out_raddr  = out_cnt_m1[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_mode == MODE_ENQ) begin
                    if (out_free) begin
                        n_o_valid = 1'b1;
                        n_o_data  = '0;
                        n_state   = S_IDLE;
                        if (in_full) begin
                            n_o_status = ST_FULL;
                        end else begin
                            n_o_status = ST_OK;
                            in_we      = 1'b1;
                            n_in_cnt   = r_in_cnt + CW'(1);
                        end
                    end
                end else if (r_out_cnt != '0) begin
                    out_re    = 1'b1;
                    n_out_cnt = out_cnt_m1;
                    n_state   = S_POP_WAIT;
                end else if (r_in_cnt != '0) begin
                    n_mv_pend = 1'b0;
                    n_state   = S_MOVE;
                end else if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = '0;
                    n_o_status = ST_EMPTY;
                    n_state    = S_IDLE;
                end
            end
            S_MOVE: begin
                // Read from the input stack and write the previous read
                // onto the output stack in the same cycle.
                if (r_mv_pend) begin
                    out_we    = 1'b1;
                    n_out_cnt = r_out_cnt + CW'(1);
                end
                if (r_in_cnt != '0) begin
                    in_re     = 1'b1;
                    n_in_cnt  = in_cnt_m1;
                    n_mv_pend = 1'b1;
                end else begin
                    n_mv_pend = 1'b0;
                    n_state   = S_POP_RD;
                end
            end
            S_POP_RD: begin
                out_re    = 1'b1;
                n_out_cnt = out_cnt_m1;
                n_state   = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = r_out_rdata;
                    n_o_status = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tuser  = r_o_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_mv_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
            r_mv_pend <= n_mv_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_data   <= n_o_data;
        r_o_status <= n_o_status;
        if (accept) begin
            r_mode  <= i_s_axis_tuser[0];
            r_value <= i_s_axis_tdata;
        end
    end

    // Input-stack memory.
    always_ff @(posedge i_clk) begin
        if (in_we) begin
            r_in_mem[in_waddr] <= r_value;
        end
        if (in_re) begin
            r_in_rdata <= r_in_mem[in_raddr];
        end
    end

    // Output-stack memory.
    always_ff @(posedge i_clk) begin
        if (out_we) begin
            r_out_mem[out_waddr] <= r_in_rdata;
        end
        if (out_re) begin
            r_out_rdata <= r_out_mem[out_raddr];
        end
    end

endmodule

@@ rtl/core/tsq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_checker
// Port-level checks for the two-stack queue, attached to the top level.
// ----------------------------------------------------------------------------
module tsq_checker
    import tsq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [DATA_W-1:0] o_m_axis_tdata,
    input logic [STAT_W-1:0] o_m_axis_tuser
);

    // A stalled result item keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_FULL ||
             o_m_axis_tuser == ST_EMPTY))
        else $error("undefined status code");

    // Errors carry a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> o_m_axis_tdata == '0)
        else $error("error result with nonzero value");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item accepted while one is in work");

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-stack queue. Items are driven on the input
// stream and a local queue model predicts every result. Each result taken
// from the output stream is checked in order against the oldest prediction.
// A short table of directed items comes first. Random bursts follow: fills
// up to the full stack, drains past empty, and mixed runs. Both stream sides
// stall at random in changing proportions.
// ----------------------------------------------------------------------------
module testbench;
    import tsq_pkg::*;

    localparam int DEPTH        = 128;
    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int DRAIN_CYCLES = 20000;
    localparam int SETTLE       = 2 * DEPTH + 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
    } t_queue_result;

    typedef struct packed {
        logic              mode;
        logic [DATA_W-1:0] value;
        logic              typed;
        t_queue_result     result;
    } t_directed_row;

    // The expected result is typed in where it is plain to see; other rows
    // are checked against the queue model.
    localparam t_directed_row DIRECTED [0:13] = '{
        '{MODE_DEQ, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY}},
        '{MODE_ENQ, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK}},
        '{MODE_ENQ, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK}},
        '{MODE_ENQ, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK}},
        '{MODE_ENQ, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK}},
        '{MODE_DEQ, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, ST_OK}},
        '{MODE_ENQ, 32'h5555_5555, 1'b0, '{32'h0000_0000, ST_OK}},
        '{MODE_DEQ, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK}},
        '{MODE_DEQ, 32'h1234_5678, 1'b1, '{32'h0000_0000, ST_OK}},
        '{MODE_ENQ, 32'hAAAA_AAAA, 1'b0, '{32'h0000_0000, ST_OK}},
        '{MODE_DEQ, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK}},
        '{MODE_DEQ, 32'h0000_0000, 1'b0, '{32'h0000_0000, ST_OK}},
        '{MODE_DEQ, 32'h0000_0000, 1'b0, '{32'h0000_0000, ST_OK}},
        '{MODE_DEQ, 32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, ST_EMPTY}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata = '0;   // [31:0] value_in
    logic [0:0]        i_s_axis_tuser = '0;   // [0] mode
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;        // [31:0] value_out
    logic [STAT_W-1:0] o_m_axis_tuser;        // [1:0] status

    // Queue model state.
    logic [DATA_W-1:0] in_stack  [DEPTH];
    logic [DATA_W-1:0] out_stack [DEPTH];
    int                in_depth  = 0;
    int                out_depth = 0;

    t_queue_result awaited_results [$];
    int            items_sent     = 0;
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            dst_idle_pct   = 0;

    two_stack_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic t_queue_result apply_queue_op(input logic mode,
                                                     input logic [DATA_W-1:0] value);
        t_queue_result r;
        r.value  = '0;
        r.status = ST_OK;
        if (mode == MODE_ENQ) begin
            if (in_depth >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                in_stack[in_depth] = value;
                in_depth++;
            end
        end else begin
            // The output stack is refilled only once it has run dry; the input
            // stack is poured over top first, which restores arrival order.
            if (out_depth == 0) begin
                while (in_depth > 0) begin
                    in_depth--;
                    out_stack[out_depth] = in_stack[in_depth];
                    out_depth++;
                end
            end
            if (out_depth == 0) begin
                r.status = ST_EMPTY;
            end else begin
                out_depth--;
                r.value = out_stack[out_depth];
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic mode, input logic [DATA_W-1:0] value,
                             input logic typed, input t_queue_result typed_result);
        t_queue_result r;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        i_s_axis_tvalid   <= 1'b1;
        i_s_axis_tdata    <= value;
        i_s_axis_tuser[0] <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = apply_queue_op(mode, value);
        if (typed) begin
            r = typed_result;
        end
        awaited_results.push_back(r);
        items_sent++;
    endtask

    task automatic send_random(input logic mode);
        send_item(mode, $urandom, 1'b0, '0);
    endtask

    // Holds the input side quiet until every pending result has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Fills the input stack to the top, then pushes a few more that are refused.
    task automatic fill_stack();
        while (in_depth < DEPTH) begin
            send_random(MODE_ENQ);
        end
        repeat ($urandom_range(1, 3)) send_random(MODE_ENQ);
    endtask

    always @(posedge i_clk) begin : result_check
        t_queue_result exp_r;
        i_m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result: value %h status %0d",
                             o_m_axis_tdata, o_m_axis_tuser);
                end
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_m_axis_tdata !== exp_r.value || o_m_axis_tuser !== exp_r.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: value exp %h got %h, status exp %0d got %0d",
                                 exp_r.value, o_m_axis_tdata, exp_r.status, o_m_axis_tuser);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int phase_start;
        int kind;
        int len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 29;
        dst_idle_pct = 68;
        for (int i = 0; i < $size(DIRECTED); i++) begin
            send_item(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].typed,
                      DIRECTED[i].result);
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 68 : 0;
            dst_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 29 : 0;
            wait_drained();
            phase_start = items_sent;
            if (phase == 0) begin
                // Full input stack while the output stack still has room.
                fill_stack();
                send_random(MODE_DEQ);
                fill_stack();
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                kind = $urandom_range(0, 19);
                len  = $urandom_range(1, 24);
                if (kind < 2) begin
                    fill_stack();
                end else if (kind < 4) begin
                    while (in_depth + out_depth > 0) begin
                        send_random(MODE_DEQ);
                    end
                    repeat ($urandom_range(1, 2)) send_random(MODE_DEQ);
                end else if (kind < 9) begin
                    repeat (len) send_random(MODE_ENQ);
                end else if (kind < 14) begin
                    repeat (len) send_random(MODE_DEQ);
                end else if (kind < 19) begin
                    repeat (len) send_random(logic'($urandom_range(0, 1)));
                end else begin
                    wait_drained();
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        for (int k = 0; k < DRAIN_CYCLES && awaited_results.size() != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
        mismatch_count += awaited_results.size();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
